// ===== src/utf8_sanitizer_macros.svh =====
// ----------------------------------------------------------------------------
// utf8_sanitizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_MACROS_SVH
`define UTF8_SANITIZER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define UTF8S_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold at the next clock.
`define UTF8S_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/utf8s_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types and byte-class constants shared by the UTF-8 sanitizer modules.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    localparam int unsigned MAX_OUT = 4;

    localparam logic [6:0] REPL_RESET = 7'd63;

    // Byte classes: (byte & mask) == code.
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Continuation bytes that a held sequence needs in all; zero means none held.
    localparam logic [1:0] NEED_NONE  = 2'd0;
    localparam logic [1:0] NEED_LEAD2 = 2'd1;
    localparam logic [1:0] NEED_LEAD3 = 2'd2;
    localparam logic [1:0] NEED_LEAD4 = 2'd3;

    // Sequence tracking state.
    typedef struct packed {
        logic [7:0] lead;
        logic [1:0] need;
        logic [1:0] cnt;
    } seq_state_t;

    // Up to four result bytes caused by one input beat.
    typedef struct packed {
        logic [2:0]       count;
        logic [3:0][7:0]  bytes;
        logic             eot;
    } result_t;

endpackage
`default_nettype wire

// ===== src/utf8_sanitizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_sanitizer
// UTF-8 sanitizing byte filter: passes whole sequences, replaces bad bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake            Payload
//   s_*       in   s_tvalid/s_tready    s_tdata = in_byte, s_tlast = end_of_text
//   m_*       out  m_tvalid/m_tready    m_tdata = out_byte, m_tlast = run_last,
//                                       m_tuser = text_done
//   cfg_*     in   cfg_we               cfg_wdata = replacement_byte
//
// Each input beat is decoded combinationally against the sequence state and its
// zero to four result bytes land together in the result register. The result
// register sends one byte per beat, so an input beat that causes several results
// occupies the output until all of them have been sent. A new input beat is taken
// in the same cycle as the last result beat of the previous one leaves. Reset
// clears the held sequence, empties the result register and restores the
// replacement byte to '?'. s_tready is low while result beats remain to be sent,
// apart from the cycle in which m_tready takes the last of them, so back-pressure
// on m_* reaches s_* in the same cycle.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_macros.svh"

module utf8_sanitizer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
    input  wire logic        s_tlast,    // end_of_text

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_byte
    output logic             m_tlast,    // run_last
    output logic             m_tuser,    // [0] text_done

    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata   // [6:0] replacement_byte
);

    utf8s_pkg::seq_state_t state_reg;
    utf8s_pkg::seq_state_t state_next;
    logic [1:0][7:0]       conts_reg;
    logic [6:0]            repl_reg;
    logic                  cont_we;
    logic                  cont_idx;
    utf8s_pkg::result_t    res;
    logic                  accept;
    logic                  load;

    assign accept = s_tvalid && s_tready;
    // Beats that only start or extend a held sequence produce nothing to queue.
    assign load   = accept && (res.count != 3'd0);

    utf8s_step u_step
    (
        .st       (state_reg),
        .conts    (conts_reg),
        .repl     (repl_reg),
        .in_byte  (s_tdata),
        .eot      (s_tlast),
        .st_next  (state_next),
        .cont_we  (cont_we),
        .cont_idx (cont_idx),
        .res      (res)
    );

    utf8s_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            repl_reg  <= utf8s_pkg::REPL_RESET;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                repl_reg <= cfg_wdata;
            end
        end
    end

    // Held continuation bytes are only read once written, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (accept && cont_we)
        begin
            conts_reg[cont_idx] <= s_tdata;
        end
    end

    `UTF8S_ASSERT_IMP(a_idle_clear, state_reg.need == utf8s_pkg::NEED_NONE,
        (state_reg.cnt == 2'd0) && (state_reg.lead == 8'd0),
        "sequence fields set with no sequence held")
    `UTF8S_ASSERT_IMP(a_cnt_below_need, state_reg.need != utf8s_pkg::NEED_NONE,
        state_reg.cnt < state_reg.need, "held continuation count reached its target")
    `UTF8S_ASSERT_IMP(a_done_is_last, m_tvalid && m_tuser, m_tlast,
        "end of text flagged on a beat that is not the last of its run")

endmodule
`default_nettype wire

// ===== src/utf8s_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8s_step
// Combinational step: next sequence state and result bytes for one input beat.
// ----------------------------------------------------------------------------
module utf8s_step
(
    input  wire utf8s_pkg::seq_state_t       st,
    input  wire logic [1:0][7:0]             conts,
    input  wire logic [6:0]                  repl,
    input  wire logic [7:0]                  in_byte,
    input  wire logic                        eot,
    output utf8s_pkg::seq_state_t            st_next,
    output logic                             cont_we,
    output logic                             cont_idx,
    output utf8s_pkg::result_t               res
);

    logic [2:0] n;
    logic       is_cont;
    logic       fresh;

    assign is_cont  = (in_byte & utf8s_pkg::CONT_MASK) == utf8s_pkg::CONT_CODE;
    assign cont_idx = st.cnt[0];

    always_comb
    begin
        // Every slot defaults to the replacement byte, so flushes only bump n.
        res.bytes = {utf8s_pkg::MAX_OUT{{1'b0, repl}}};
        n         = 3'd0;
        st_next   = st;
        cont_we   = 1'b0;
        fresh     = 1'b1;

        if (st.need != utf8s_pkg::NEED_NONE)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (({1'b0, st.cnt} + 3'd1) >= {1'b0, st.need})
                begin
                    // Sequence complete: lead, held continuations, this byte.
                    res.bytes[0] = st.lead;
                    if (st.cnt >= 2'd1)
                    begin
                        res.bytes[1] = conts[0];
                    end
                    if (st.cnt >= 2'd2)
                    begin
                        res.bytes[2] = conts[1];
                    end
                    res.bytes[st.cnt + 2'd1] = in_byte;
                    n       = {1'b0, st.cnt} + 3'd2;
                    st_next = '0;
                end
                else
                begin
                    cont_we     = 1'b1;
                    st_next.cnt = st.cnt + 2'd1;
                end
            end
            else
            begin
                // Broken sequence: lead and held continuations are replaced.
                n       = {1'b0, st.cnt} + 3'd1;
                st_next = '0;
            end
        end

        if (fresh)
        begin
            if (!in_byte[7])
            begin
                res.bytes[n[1:0]] = in_byte;
                n = n + 3'd1;
            end
            else if ((in_byte & utf8s_pkg::LEAD2_MASK) == utf8s_pkg::LEAD2_CODE)
            begin
                st_next = '{lead: in_byte, need: utf8s_pkg::NEED_LEAD2, cnt: 2'd0};
            end
            else if ((in_byte & utf8s_pkg::LEAD3_MASK) == utf8s_pkg::LEAD3_CODE)
            begin
                st_next = '{lead: in_byte, need: utf8s_pkg::NEED_LEAD3, cnt: 2'd0};
            end
            else if ((in_byte & utf8s_pkg::LEAD4_MASK) == utf8s_pkg::LEAD4_CODE)
            begin
                st_next = '{lead: in_byte, need: utf8s_pkg::NEED_LEAD4, cnt: 2'd0};
            end
            else
            begin
                n = n + 3'd1;
            end
        end

        // Text ends inside a sequence: replace whatever is still held.
        if (eot && (st_next.need != utf8s_pkg::NEED_NONE))
        begin
            n       = n + {1'b0, st_next.cnt} + 3'd1;
            st_next = '0;
        end

        res.count = n;
        res.eot   = eot;
    end

endmodule
`default_nettype wire

// ===== src/utf8s_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8s_outq
// Result register holding one input's result bytes, sent out one per beat.
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_macros.svh"

module utf8s_outq
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire utf8s_pkg::result_t     res,
    output logic                        ready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] out_byte
    output logic                        m_tlast,   // run_last
    output logic                        m_tuser    // [0] text_done
);

    logic [2:0]      rem_reg;
    logic [2:0]      rem_next;
    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic [3:0][7:0] bytes_reg;
    logic            eot_reg;
    logic            last;

    assign last     = rem_reg == 3'd1;
    assign m_tvalid = rem_reg != 3'd0;
    assign m_tdata  = bytes_reg[pos_reg];
    assign m_tlast  = last;
    assign m_tuser  = last && eot_reg;
    assign ready    = (rem_reg == 3'd0) || (last && m_tready);

    always_comb
    begin
        rem_next = rem_reg;
        pos_next = pos_reg;
        if (load)
        begin
            rem_next = res.count;
            pos_next = 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            rem_next = rem_reg - 3'd1;
            pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            pos_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= res.bytes;
            eot_reg   <= res.eot;
        end
    end

    `UTF8S_ASSERT_IMP(a_rem_range, 1'b1, rem_reg <= 3'd4, "result count above four")
    `UTF8S_ASSERT_NXT(a_rem_step, m_tvalid && m_tready && !last && !load,
        (rem_reg == $past(rem_reg) - 3'd1) && (pos_reg == $past(pos_reg) + 2'd1),
        "result beat did not advance the queue")

endmodule
`default_nettype wire
